// ===== rtl/tbpf_pkg.sv =====
// Shared types, codes and constants of the tile background pixel fetcher.
package tbpf_pkg;

   localparam int TILE_SIZE   = 8;
   localparam int MAP_SIDE    = 32;
   localparam int ROW_W       = $clog2(TILE_SIZE);
   localparam int COL_W       = $clog2(MAP_SIDE);
   localparam int ADDR_W      = 13;
   localparam int BYTE_W      = 8;
   localparam int COLOR_W     = 2;
   localparam int PALETTE_W   = 3;
   localparam int FIFO_W      = 5;
   localparam int PIXELS      = 8;
   localparam int BEAT_W      = $clog2(PIXELS);
   // Tile data starts at id * bytes per tile; the low bits of that are the row and plane.
   localparam int TILE_BYTE_W = ROW_W + 1;
   localparam int TILE_BASE_W = ADDR_W - TILE_BYTE_W;

   localparam logic [FIFO_W-1:0] FIFO_PUSH_LIMIT = FIFO_W'(PIXELS);

   localparam logic [ADDR_W-1:0] MAP_BASE_LOW   = 13'h1800;
   localparam logic [ADDR_W-1:0] MAP_BASE_HIGH  = 13'h1C00;

   // Attribute bit positions.
   localparam int ATTR_BANK     = 3;
   localparam int ATTR_HFLIP    = 5;
   localparam int ATTR_VFLIP    = 6;
   localparam int ATTR_PRIORITY = 7;

   typedef enum logic [1:0] {
      REQ_DOT_TICK = 2'd0,
      REQ_RESTART  = 2'd1,
      REQ_SET_MODE = 2'd2,
      REQ_IGNORED  = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      STEP_GET_TILE  = 4'b0001,
      STEP_DATA_LOW  = 4'b0010,
      STEP_DATA_HIGH = 4'b0100,
      STEP_PUSH      = 4'b1000
   } fetch_step_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic              window_mode;
      logic [BYTE_W-1:0] scanline;
      logic [BYTE_W-1:0] scroll_x;
      logic [BYTE_W-1:0] scroll_y;
      logic [BYTE_W-1:0] window_line;
      logic              bg_map_select;
      logic              win_map_select;
      logic              data_area_select;
      logic [FIFO_W-1:0] fifo_count;
      logic [BYTE_W-1:0] read_bank0;
      logic [BYTE_W-1:0] read_bank1;
   } item_type;

   // One accepted item's outcome: a single beat, or eight pixel beats when push is set.
   typedef struct packed {
      logic                           mem_request;
      logic [ADDR_W-1:0]              mem_address;
      logic                           push;
      logic [PIXELS-1:0][COLOR_W-1:0] colors;
      logic [PALETTE_W-1:0]           palette_number;
      logic                           above_sprites;
   } result_type;

endpackage

// ===== rtl/tbpf_req_if.sv =====
// Input channel of the fetcher: one dot tick or control request per beat.
interface tbpf_req_if;
   import tbpf_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic              window_mode;
   logic [BYTE_W-1:0] scanline;
   logic [BYTE_W-1:0] scroll_x;
   logic [BYTE_W-1:0] scroll_y;
   logic [BYTE_W-1:0] window_line;
   logic              bg_map_select;
   logic              win_map_select;
   logic              data_area_select;
   logic [FIFO_W-1:0] fifo_count;
   logic [BYTE_W-1:0] read_bank0;
   logic [BYTE_W-1:0] read_bank1;

   modport source (
      output valid, req_type, window_mode, scanline, scroll_x, scroll_y, window_line,
             bg_map_select, win_map_select, data_area_select, fifo_count,
             read_bank0, read_bank1,
      input  ready
   );

   modport sink (
      input  valid, req_type, window_mode, scanline, scroll_x, scroll_y, window_line,
             bg_map_select, win_map_select, data_area_select, fifo_count,
             read_bank0, read_bank1,
      output ready
   );
endinterface

// ===== rtl/tbpf_rsp_if.sv =====
// Result channel of the fetcher: VRAM request and pixel beats.
interface tbpf_rsp_if;
   import tbpf_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 mem_request;
   logic [ADDR_W-1:0]    mem_address;
   logic                 pixel_valid;
   logic [COLOR_W-1:0]   color_index;
   logic [PALETTE_W-1:0] palette_number;
   logic                 above_sprites;
   logic                 last_result;

   modport source (
      output valid, mem_request, mem_address, pixel_valid, color_index, palette_number,
             above_sprites, last_result,
      input  ready
   );

   modport sink (
      input  valid, mem_request, mem_address, pixel_valid, color_index, palette_number,
             above_sprites, last_result,
      output ready
   );
endinterface

// ===== rtl/tbpf_csr_if.sv =====
// Configuration write channel of the fetcher: carries the color mode bit.
interface tbpf_csr_if;
   logic valid;
   logic ready;
   logic color_mode;

   modport source (output valid, color_mode, input ready);
   modport sink (input valid, color_mode, output ready);
endinterface

// ===== rtl/tbpf_fetch_core.sv =====
// Fetcher step sequencer: tile, plane and attribute state and the outcome of one item.
module tbpf_fetch_core
   import tbpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_accept,
   input  item_type   item,
   input  logic       color_mode,
   output result_type result
);

   fetch_step_type         step_ff, step_in;
   logic                   tick_ff, tick_in;
   logic [COL_W-1:0]       column_ff, column_in;
   logic                   window_ff, window_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [TILE_BASE_W-1:0] tile_base_ff, tile_base_in;
   logic [BYTE_W-1:0]      plane_low_ff, plane_low_in;
   logic [BYTE_W-1:0]      plane_high_ff, plane_high_in;
   logic [BYTE_W-1:0]      attr_ff, attr_in;

   logic [BYTE_W-1:0]      start_line;
   logic [COL_W-1:0]       map_column;
   logic [ADDR_W-1:0]      map_address;
   logic [ROW_W-1:0]       plane_row;
   logic [BYTE_W-1:0]      bank_byte;
   logic                   signed_area;
   logic [PIXELS-1:0][COLOR_W-1:0] row_colors;

   always_comb begin
      start_line = window_ff ? item.window_line : item.scanline + item.scroll_y;
      map_column = window_ff ? column_ff
                             : item.scroll_x[BYTE_W-1:ROW_W] + column_ff;
      map_address = ((window_ff ? item.win_map_select : item.bg_map_select)
                       ? MAP_BASE_HIGH : MAP_BASE_LOW)
                    + ADDR_W'({start_line[ROW_W+COL_W-1:ROW_W], map_column});
      plane_row   = row_ff ^ {ROW_W{attr_ff[ATTR_VFLIP]}};
      bank_byte   = attr_ff[ATTR_BANK] ? item.read_bank1 : item.read_bank0;
      // Signed ids below 128 sit above the 0x1000 boundary; the rest wrap to id * 16.
      signed_area = !(item.data_area_select || item.read_bank0[BYTE_W-1]);
   end

   always_comb begin
      for (int x = 0; x < PIXELS; x++) begin
         logic [BEAT_W-1:0] pos;
         pos = attr_ff[ATTR_HFLIP] ? BEAT_W'(x) : BEAT_W'(PIXELS - 1 - x);
         row_colors[x] = {plane_high_ff[pos], plane_low_ff[pos]};
      end
   end

   always_comb begin
      step_in       = step_ff;
      tick_in       = tick_ff;
      column_in     = column_ff;
      window_in     = window_ff;
      row_in        = row_ff;
      tile_base_in  = tile_base_ff;
      plane_low_in  = plane_low_ff;
      plane_high_in = plane_high_ff;
      attr_in       = attr_ff;
      result        = '0;

      case (req_code_type'(item.req_type))
         REQ_RESTART: begin
            column_in = '0;
            step_in   = STEP_GET_TILE;
            tick_in   = 1'b0;
         end
         REQ_SET_MODE: begin
            window_in = item.window_mode;
         end
         REQ_DOT_TICK: begin
            case (step_ff)
               STEP_GET_TILE: begin
                  if (!tick_ff) begin
                     result.mem_request = 1'b1;
                     result.mem_address = map_address;
                     row_in             = start_line[ROW_W-1:0];
                     column_in          = column_ff + 1'b1;
                     tick_in            = 1'b1;
                  end else begin
                     attr_in      = color_mode ? item.read_bank1 : '0;
                     tile_base_in = {signed_area, item.read_bank0};
                     step_in      = STEP_DATA_LOW;
                     tick_in      = 1'b0;
                  end
               end
               STEP_DATA_LOW: begin
                  if (!tick_ff) begin
                     result.mem_request = 1'b1;
                     result.mem_address = {tile_base_ff, plane_row, 1'b0};
                     tick_in            = 1'b1;
                  end else begin
                     plane_low_in = bank_byte;
                     step_in      = STEP_DATA_HIGH;
                     tick_in      = 1'b0;
                  end
               end
               STEP_DATA_HIGH: begin
                  if (!tick_ff) begin
                     result.mem_request = 1'b1;
                     result.mem_address = {tile_base_ff, plane_row, 1'b1};
                     tick_in            = 1'b1;
                  end else begin
                     plane_high_in = bank_byte;
                     step_in       = STEP_PUSH;
                     tick_in       = 1'b0;
                  end
               end
               STEP_PUSH: begin
                  // Stall while the pixel FIFO cannot take a full row.
                  if (item.fifo_count <= FIFO_PUSH_LIMIT) begin
                     result.push           = 1'b1;
                     result.colors         = row_colors;
                     result.palette_number = attr_ff[PALETTE_W-1:0];
                     result.above_sprites  = attr_ff[ATTR_PRIORITY];
                     step_in               = STEP_GET_TILE;
                     tick_in               = 1'b0;
                  end
               end
               default: begin
                  step_in = STEP_GET_TILE;
                  tick_in = 1'b0;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_GET_TILE;
         tick_ff       <= 1'b0;
         column_ff     <= '0;
         window_ff     <= 1'b0;
         row_ff        <= '0;
         tile_base_ff  <= '0;
         plane_low_ff  <= '0;
         plane_high_ff <= '0;
         attr_ff       <= '0;
      end else if (item_accept) begin
         step_ff       <= step_in;
         tick_ff       <= tick_in;
         column_ff     <= column_in;
         window_ff     <= window_in;
         row_ff        <= row_in;
         tile_base_ff  <= tile_base_in;
         plane_low_ff  <= plane_low_in;
         plane_high_ff <= plane_high_in;
         attr_ff       <= attr_in;
      end
   end

endmodule

// ===== rtl/tile_background_pixel_fetcher_top.sv =====
// Top level of the tile background pixel fetcher: channels, result register and beat serializer.
//
// Background/window tile fetcher for a tile-based pixel pipeline. Each req beat is one dot
// tick (or a restart / set-mode request); the fetcher walks GetTile, plane low, plane high
// and Push; each of the first three steps asks for a VRAM read on its first tick, and each
// non-push tick answers with one rsp beat carrying the read it wants, if any (the answer
// comes back in read_bank0/1 of the next tick). A Push tick with the pixel FIFO holding
// eight or fewer pixels answers with eight pixel beats, leftmost first, the last flagged by
// last_result; a fuller FIFO stalls the fetcher for that tick. All state updates happen in
// the accepting cycle and the outcome lands in one result register, so a new req beat is
// taken every cycle while rsp keeps up and no push is draining through the single pixel
// lane of the serializer. The next req beat is taken in the same cycle the final rsp beat
// leaves. color_mode is written on the csr channel, which is always ready.
module tile_background_pixel_fetcher_top
   import tbpf_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   tbpf_req_if.sink   req_bus,
   tbpf_rsp_if.source rsp_bus,
   tbpf_csr_if.sink   csr_bus
);

   item_type          item;
   result_type        result;
   result_type        held_ff;
   logic              held_valid_ff;
   logic [BEAT_W-1:0] beat_ff;
   logic              color_mode_ff;
   logic              item_accept;
   logic              rsp_fire;
   logic              rsp_last;

   assign item = '{
      req_type:         req_bus.req_type,
      window_mode:      req_bus.window_mode,
      scanline:         req_bus.scanline,
      scroll_x:         req_bus.scroll_x,
      scroll_y:         req_bus.scroll_y,
      window_line:      req_bus.window_line,
      bg_map_select:    req_bus.bg_map_select,
      win_map_select:   req_bus.win_map_select,
      data_area_select: req_bus.data_area_select,
      fifo_count:       req_bus.fifo_count,
      read_bank0:       req_bus.read_bank0,
      read_bank1:       req_bus.read_bank1
   };

   // Take a new item when the result register is empty or drains its final beat now.
   assign rsp_last    = !held_ff.push || (beat_ff == BEAT_W'(PIXELS - 1));
   assign rsp_fire    = held_valid_ff && rsp_bus.ready;
   assign req_bus.ready = !held_valid_ff || (rsp_bus.ready && rsp_last);
   assign item_accept = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   tbpf_fetch_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_accept(item_accept),
      .item       (item),
      .color_mode (color_mode_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         color_mode_ff <= csr_bus.color_mode;
      end
   end

   // Hold the outcome and advance through its beats.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         beat_ff       <= '0;
      end else if (item_accept) begin
         held_valid_ff <= 1'b1;
         beat_ff       <= '0;
      end else if (rsp_fire) begin
         if (rsp_last) begin
            held_valid_ff <= 1'b0;
         end
         beat_ff <= beat_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (item_accept) begin
         held_ff <= result;
      end
   end

   assign rsp_bus.valid          = held_valid_ff;
   assign rsp_bus.mem_request    = held_ff.mem_request;
   assign rsp_bus.mem_address    = held_ff.mem_address;
   assign rsp_bus.pixel_valid    = held_ff.push;
   assign rsp_bus.color_index    = held_ff.push ? held_ff.colors[beat_ff] : '0;
   assign rsp_bus.palette_number = held_ff.palette_number;
   assign rsp_bus.above_sprites  = held_ff.above_sprites;
   assign rsp_bus.last_result    = rsp_last;

endmodule
